FILE: hw/rtl/strip_chart_sample_plotter_unit_defines.svh
// assertion macros used by the checker file
`ifndef STRIP_CHART_SAMPLE_PLOTTER_UNIT_DEFINES_SVH
`define STRIP_CHART_SAMPLE_PLOTTER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define SCSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scsp same-cycle check failed");

// next-cycle implication
`define SCSP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scsp next-cycle check failed");

`endif

FILE: hw/rtl/scsp_pkg.sv
package scsp_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    // draw command codes
    localparam logic [1:0] OP_FILL  = 2'd0;
    localparam logic [1:0] OP_LINE  = 2'd1;
    localparam logic [1:0] OP_PIXEL = 2'd2;

    // register map, word index
    localparam logic [2:0] REG_FRAME_X      = 3'd0;
    localparam logic [2:0] REG_FRAME_Y      = 3'd1;
    localparam logic [2:0] REG_FRAME_W      = 3'd2;
    localparam logic [2:0] REG_FRAME_H      = 3'd3;
    localparam logic [2:0] REG_TITLE_HEIGHT = 3'd4;
    localparam logic [2:0] REG_MIN_VALUE    = 3'd5;
    localparam logic [2:0] REG_MAX_VALUE    = 3'd6;
    localparam logic [2:0] REG_COLOR_PAIR   = 3'd7;

    typedef struct packed {
        logic [15:0] frame_x;
        logic [15:0] frame_y;
        logic [15:0] frame_w;
        logic [15:0] frame_h;
        logic [7:0]  title_height;
        logic [15:0] min_value;
        logic [15:0] max_value;
        logic [31:0] color_pair;
    } cfg_t;

    // classified sample waiting for the back end
    typedef struct packed {
        logic [15:0] diff;       // clamped sample minus min_value
        logic        zero_scale; // row offset is zero, no divide needed
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

FILE: hw/rtl/scsp_front.sv
module scsp_front
    import scsp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [15:0]   sample,
    input  cfg_t          cfg,
    input  queue_status_t qstat,
    output logic          push,
    output entry_t        push_entry
);

    localparam logic [15:0] CMASK = 16'((32'd1 << COORD_BITS) - 32'd1);

    logic [15:0] fw;
    logic [15:0] fh;
    logic [16:0] used_h;
    logic        empty_area;
    logic        one_row;
    logic [15:0] clamped;

    assign fw     = cfg.frame_w & CMASK;
    assign fh     = cfg.frame_h & CMASK;
    assign used_h = 17'(cfg.title_height) + 17'd2;

    // no data area: sample is taken and dropped
    assign empty_area = (fw <= 16'd2) || ({1'b0, fh} <= used_h);
    assign one_row    = {1'b0, fh} <= (used_h + 17'd1);

    always_comb
    begin
        if (sample < cfg.min_value)
        begin
            clamped = cfg.min_value;
        end
        else if (sample > cfg.max_value)
        begin
            clamped = cfg.max_value;
        end
        else
        begin
            clamped = sample;
        end
    end

    assign in_stall = qstat.full;
    assign push     = in_valid && !qstat.full && !empty_area;

    assign push_entry.diff       = clamped - cfg.min_value;
    assign push_entry.zero_scale = one_row || (cfg.max_value <= cfg.min_value);

endmodule

FILE: hw/rtl/scsp_queue.sv
module scsp_queue
    import scsp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  entry_t        push_entry,
    input  logic          pop,
    output entry_t        pop_entry,
    output queue_status_t qstat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t        mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == CW'(DEPTH));
    assign pop_entry   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hw/rtl/scsp_div.sv
module scsp_div
#(
    parameter int NW = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] numer,
    input  logic [15:0]   denom,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int KW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [NW-1:0] num_next;
    logic [15:0]   rem_reg;
    logic [15:0]   rem_next;
    logic [15:0]   den_reg;
    logic [KW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [16:0]   rem_sh;
    logic [16:0]   rem_sub;

    // one quotient bit per cycle, restoring
    assign rem_sh  = {rem_reg, num_reg[NW-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        if (rem_sh >= {1'b0, den_reg})
        begin
            rem_next = rem_sub[15:0];
            num_next = {num_reg[NW-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh[15:0];
            num_next = {num_reg[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= KW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == KW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

FILE: hw/rtl/scsp_back.sv
module scsp_back
    import scsp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  queue_status_t qstat,
    input  entry_t        pop_entry,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [1:0]    op,
    output logic [15:0]   x0,
    output logic [15:0]   y0,
    output logic [15:0]   x1,
    output logic [15:0]   y1,
    output logic [15:0]   color,
    output logic          last
);

    localparam logic [15:0] CMASK = 16'((32'd1 << COORD_BITS) - 32'd1);
    localparam int          NW    = 16 + COORD_BITS;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_DIV   = 5'b00100,
        S_RECT  = 5'b01000,
        S_TRACE = 5'b10000
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;

    logic [15:0] cursor_reg;
    logic [15:0] prev_x_reg;
    logic [15:0] prev_y_reg;
    logic        prev_valid_reg;
    logic        swapped_reg;

    logic [15:0] x_reg;
    logic        line_reg;
    logic [15:0] diff_reg;
    logic [15:0] scaled_reg;
    logic [31:0] prod_reg;
    logic        div_start_reg;

    logic        out_valid_reg;
    logic [1:0]  op_reg;
    logic [15:0] x0_reg;
    logic [15:0] y0_reg;
    logic [15:0] x1_reg;
    logic [15:0] y1_reg;
    logic [15:0] color_reg;
    logic        last_reg;

    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] dw;
    logic [15:0] dh;
    logic [15:0] range;
    logic        wrap;
    logic [15:0] cur;
    logic [15:0] x_now;
    logic [15:0] y_now;
    logic [15:0] bg;
    logic [15:0] fg;
    logic        out_free;
    logic        div_done;
    logic [NW-1:0] div_quo;

    // data area geometry, wrapped to the coordinate width
    assign dx    = (cfg.frame_x + 16'd1) & CMASK;
    assign dy    = (cfg.frame_y + 16'd1 + 16'(cfg.title_height)) & CMASK;
    assign dw    = (cfg.frame_w & CMASK) - 16'd2;
    assign dh    = ((cfg.frame_h & CMASK) - 16'd2 - 16'(cfg.title_height)) & CMASK;
    assign range = cfg.max_value - cfg.min_value;

    assign wrap  = cursor_reg >= dw;
    assign cur   = wrap ? 16'd0 : cursor_reg;
    assign x_now = (dx + cur) & CMASK;
    assign y_now = (dy + dh - 16'd1 - scaled_reg) & CMASK;

    assign bg = swapped_reg ? cfg.color_pair[31:16] : cfg.color_pair[15:0];
    assign fg = swapped_reg ? cfg.color_pair[15:0] : cfg.color_pair[31:16];

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == S_IDLE) && !qstat.empty;

    scsp_div #(
        .NW (NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .numer    (prod_reg[NW-1:0]),
        .denom    (range),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = pop_entry.zero_scale ? S_RECT : S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_RECT;
                end
            end
            S_RECT:
            begin
                if (out_free)
                begin
                    state_next = S_TRACE;
                end
            end
            S_TRACE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cursor_reg     <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_valid_reg <= 1'b0;
            swapped_reg    <= 1'b0;
            div_start_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= (state_reg == S_MUL);

            if (pop)
            begin
                cursor_reg <= cur + 16'd1;
                if (wrap)
                begin
                    swapped_reg    <= !swapped_reg;
                    prev_valid_reg <= 1'b0;
                end
            end

            if ((state_reg == S_TRACE) && out_free)
            begin
                prev_x_reg     <= x_reg;
                prev_y_reg     <= y_now;
                prev_valid_reg <= 1'b1;
            end

            if (((state_reg == S_RECT) || (state_reg == S_TRACE)) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            x_reg      <= x_now;
            line_reg   <= prev_valid_reg && !wrap && (cursor_reg != 16'd0);
            diff_reg   <= pop_entry.diff;
            scaled_reg <= '0;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= diff_reg * (dh - 16'd1);
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            scaled_reg <= div_quo[15:0];
        end

        if ((state_reg == S_RECT) && out_free)
        begin
            op_reg    <= OP_FILL;
            x0_reg    <= x_reg;
            y0_reg    <= dy;
            x1_reg    <= 16'd1;
            y1_reg    <= dh;
            color_reg <= bg;
            last_reg  <= 1'b0;
        end
        else if ((state_reg == S_TRACE) && out_free)
        begin
            color_reg <= fg;
            last_reg  <= 1'b1;
            x1_reg    <= x_reg;
            y1_reg    <= y_now;
            if (line_reg)
            begin
                op_reg <= OP_LINE;
                x0_reg <= prev_x_reg;
                y0_reg <= prev_y_reg;
            end
            else
            begin
                op_reg <= OP_PIXEL;
                x0_reg <= x_reg;
                y0_reg <= y_now;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign op        = op_reg;
    assign x0        = x0_reg;
    assign y0        = y0_reg;
    assign x1        = x1_reg;
    assign y1        = y1_reg;
    assign color     = color_reg;
    assign last      = last_reg;

endmodule

FILE: hw/rtl/strip_chart_sample_plotter_unit.sv
// channel   direction  handshake             payload
// input     in         in_valid / in_stall   sample
// output    out        out_valid / out_stall op, x0, y0, x1, y1, color, last
// config    in         apb write / read      frame_x .. color_pair, 4-byte stride
//
// each sample with a non-empty data area yields two transfers: a clear
// rectangle and then a line or pixel; the steps per sample are pop, multiply,
// divider start, one divider step per quotient bit (16 + COORD_BITS bits),
// divider done and the two emits
// the bit-serial divider sets the time per sample; a sample with max at or
// below min, or a one-row area, skips multiply and divide
// samples with an empty data area are taken while the queue is not full and dropped
// rst_n clears the config registers to their reset values and the control state
// out_stall holds the output register; the queue keeps taking samples until full
module strip_chart_sample_plotter_unit
    import scsp_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    // sample input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] sample,

    // draw command output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  op,
    output logic [15:0] x0,
    output logic [15:0] y0,
    output logic [15:0] x1,
    output logic [15:0] y1,
    output logic [15:0] color,
    output logic        last,

    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t          cfg_reg;
    logic          cfg_write;
    logic [2:0]    reg_idx;

    queue_status_t qstat;
    logic          push;
    logic          pop;
    entry_t        push_entry;
    entry_t        pop_entry;

    // ---------------------------------------------------------------
    // register file, written in the access phase
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_x      <= 16'h0000;
            cfg_reg.frame_y      <= 16'h0000;
            cfg_reg.frame_w      <= 16'h0000;
            cfg_reg.frame_h      <= 16'h0000;
            cfg_reg.title_height <= 8'h00;
            cfg_reg.min_value    <= 16'h0000;
            cfg_reg.max_value    <= 16'hFFFF;
            cfg_reg.color_pair   <= 32'hFFFF_0000;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_FRAME_X:      cfg_reg.frame_x      <= pwdata[15:0];
                REG_FRAME_Y:      cfg_reg.frame_y      <= pwdata[15:0];
                REG_FRAME_W:      cfg_reg.frame_w      <= pwdata[15:0];
                REG_FRAME_H:      cfg_reg.frame_h      <= pwdata[15:0];
                REG_TITLE_HEIGHT: cfg_reg.title_height <= pwdata[7:0];
                REG_MIN_VALUE:    cfg_reg.min_value    <= pwdata[15:0];
                REG_MAX_VALUE:    cfg_reg.max_value    <= pwdata[15:0];
                REG_COLOR_PAIR:   cfg_reg.color_pair   <= pwdata;
                default:          cfg_reg.frame_x      <= cfg_reg.frame_x;
            endcase
        end
    end

    // read mux, zero-extended to the bus width
    always_comb
    begin
        unique case (reg_idx)
            REG_FRAME_X:      prdata = 32'(cfg_reg.frame_x);
            REG_FRAME_Y:      prdata = 32'(cfg_reg.frame_y);
            REG_FRAME_W:      prdata = 32'(cfg_reg.frame_w);
            REG_FRAME_H:      prdata = 32'(cfg_reg.frame_h);
            REG_TITLE_HEIGHT: prdata = 32'(cfg_reg.title_height);
            REG_MIN_VALUE:    prdata = 32'(cfg_reg.min_value);
            REG_MAX_VALUE:    prdata = 32'(cfg_reg.max_value);
            REG_COLOR_PAIR:   prdata = cfg_reg.color_pair;
            default:          prdata = 32'h0000_0000;
        endcase
    end

    // ---------------------------------------------------------------
    // front end: take the sample, drop it if the area is empty,
    // clamp and flag the trivial row cases
    // ---------------------------------------------------------------
    scsp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .cfg        (cfg_reg),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    // short queue so the input keeps flowing while the back end divides
    scsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .qstat      (qstat)
    );

    // ---------------------------------------------------------------
    // back end: cursor and palette state, scale to a row, emit commands
    // ---------------------------------------------------------------
    scsp_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .qstat     (qstat),
        .pop_entry (pop_entry),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .op        (op),
        .x0        (x0),
        .y0        (y0),
        .x1        (x1),
        .y1        (y1),
        .color     (color),
        .last      (last)
    );

endmodule

FILE: hw/rtl/scsp_checker.sv
`include "strip_chart_sample_plotter_unit_defines.svh"

module scsp_checker
    import scsp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  op,
    input logic [15:0] x1,
    input logic        last
);

    // a stalled command stays offered
    `SCSP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // only the three command codes appear
    `SCSP_ASSERT_IMP(a_op_known, clk, rst_n, out_valid, op == OP_FILL || op == OP_LINE || op == OP_PIXEL)

    // the clear rectangle opens a sample, one column wide
    `SCSP_ASSERT_IMP(a_fill_first, clk, rst_n, out_valid && op == OP_FILL, !last && x1 == 16'd1)

    // line or pixel closes a sample
    `SCSP_ASSERT_IMP(a_trace_last, clk, rst_n, out_valid && op != OP_FILL, last)

endmodule

bind strip_chart_sample_plotter_unit scsp_checker u_scsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .op        (op),
    .x1        (x1),
    .last      (last)
);

FILE: test/strip_chart_sample_plotter_unit_tb.sv
`timescale 1ns / 1ps

module strip_chart_sample_plotter_unit_tb;
    import scsp_pkg::*;

    // cycles to let a dropped or queued sample clear the block before a register write
    localparam int DRAIN_CYCLES = 100;
    // mismatches printed in full, later ones are only counted
    localparam int SHOW_LIMIT   = 10;
    // stimulus row whose results come from the plot predictor
    localparam int FROM_PLOTTER = -1;

    // one draw command as it leaves the block
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] x0;
        logic [15:0] y0;
        logic [15:0] x1;
        logic [15:0] y1;
        logic [15:0] color;
        logic        last;
    } draw_cmd_t;

    // directed stimulus: a register write or a sample, with typed results where obvious
    typedef struct {
        bit          is_write;
        logic [2:0]  idx;
        logic [31:0] value;
        int          n_typed;
        draw_cmd_t   r0;
        draw_cmd_t   r1;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] sample;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  op;
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
    logic [15:0] color;
    logic        last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    strip_chart_sample_plotter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .op        (op),
        .x0        (x0),
        .y0        (y0),
        .x1        (x1),
        .y1        (y1),
        .color     (color),
        .last      (last),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // predictor copy of the registers and the plot state
    cfg_t        plot_cfg;
    logic [15:0] col_cursor;
    logic [15:0] last_x;
    logic [15:0] last_y;
    bit          last_ok;
    bit          palette_swapped;

    // draw commands still owed by the block, oldest first
    draw_cmd_t   cmd_q[$];
    draw_cmd_t   got_cmd;
    draw_cmd_t   want_cmd;
    int          mismatch_count = 0;

    // idle rates in percent, changed per phase
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    stim_row_t   stim_rows[$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver stalls at random, independent of anything else
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // compare every output transfer against the oldest owed command
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_cmd = {op, x0, y0, x1, y1, color, last};
            if (cmd_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOW_LIMIT)
                    $display("unexpected command op=%0d x0=%0d y0=%0d x1=%0d y1=%0d color=%h last=%0d",
                             op, x0, y0, x1, y1, color, last);
            end
            else
            begin
                want_cmd = cmd_q.pop_front();
                if (got_cmd !== want_cmd)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT)
                    begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected op=%0d x0=%0d y0=%0d x1=%0d y1=%0d color=%h last=%0d",
                                 want_cmd.op, want_cmd.x0, want_cmd.y0, want_cmd.x1,
                                 want_cmd.y1, want_cmd.color, want_cmd.last);
                        $display("  actual   op=%0d x0=%0d y0=%0d x1=%0d y1=%0d color=%h last=%0d",
                                 got_cmd.op, got_cmd.x0, got_cmd.y0, got_cmd.x1,
                                 got_cmd.y1, got_cmd.color, got_cmd.last);
                    end
                end
            end
        end
    end

    function automatic draw_cmd_t mk_cmd(input logic [1:0] o, input logic [15:0] a,
                                         input logic [15:0] b, input logic [15:0] c,
                                         input logic [15:0] d, input logic [15:0] col,
                                         input logic l);
        mk_cmd = {o, a, b, c, d, col, l};
    endfunction

    // advance the plot state for one sample; queue its commands when keep is set
    function void plot_sample(input logic [15:0] smp, input bit keep);
        int unsigned       fw;
        int unsigned       fh;
        int unsigned       used_h;
        int unsigned       dw;
        int unsigned       dh;
        int unsigned       clamped;
        int unsigned       span;
        int unsigned       scaled;
        longint unsigned   prod;
        logic [15:0]       dx;
        logic [15:0]       dy;
        logic [15:0]       px;
        logic [15:0]       py;
        logic [15:0]       bg;
        logic [15:0]       fg;
        logic [15:0]       tmp;
        fw     = plot_cfg.frame_w;
        fh     = plot_cfg.frame_h;
        used_h = 2 + plot_cfg.title_height;
        // empty data area: sample dropped, state untouched
        if (fw <= 2 || fh <= used_h)
            return;
        dx = plot_cfg.frame_x + 16'd1;
        dy = plot_cfg.frame_y + 16'd1 + plot_cfg.title_height;
        dw = fw - 2;
        dh = fh - used_h;
        // cursor ran off the right edge (or the area shrank): wrap and swap colors
        if (col_cursor >= dw)
        begin
            col_cursor      = '0;
            last_ok         = 1'b0;
            palette_swapped = !palette_swapped;
        end
        px = dx + col_cursor;
        if (dh <= 1)
            py = dy;
        else
        begin
            scaled = 0;
            if (plot_cfg.max_value > plot_cfg.min_value)
            begin
                clamped = smp;
                span    = plot_cfg.max_value - plot_cfg.min_value;
                if (clamped < plot_cfg.min_value)
                    clamped = plot_cfg.min_value;
                else if (clamped > plot_cfg.max_value)
                    clamped = plot_cfg.max_value;
                prod   = clamped - plot_cfg.min_value;
                prod   = prod * (dh - 1);
                scaled = prod / span;
            end
            py = dy + dh - 1 - scaled;
        end
        bg = plot_cfg.color_pair[15:0];
        fg = plot_cfg.color_pair[31:16];
        if (palette_swapped)
        begin
            tmp = bg;
            bg  = fg;
            fg  = tmp;
        end
        if (keep)
        begin
            cmd_q.push_back(mk_cmd(OP_FILL, px, dy, 16'd1, dh[15:0], bg, 1'b0));
            if (last_ok && col_cursor != 0)
                cmd_q.push_back(mk_cmd(OP_LINE, last_x, last_y, px, py, fg, 1'b1));
            else
                cmd_q.push_back(mk_cmd(OP_PIXEL, px, py, px, py, fg, 1'b1));
        end
        last_x     = px;
        last_y     = py;
        last_ok    = 1'b1;
        col_cursor = col_cursor + 16'd1;
    endfunction

    // apb write: setup cycle, then access until pready
    task cfg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // bus idle between transfers
        @(posedge clk);
        case (idx)
            REG_FRAME_X:      plot_cfg.frame_x      = val[15:0];
            REG_FRAME_Y:      plot_cfg.frame_y      = val[15:0];
            REG_FRAME_W:      plot_cfg.frame_w      = val[15:0];
            REG_FRAME_H:      plot_cfg.frame_h      = val[15:0];
            REG_TITLE_HEIGHT: plot_cfg.title_height = val[7:0];
            REG_MIN_VALUE:    plot_cfg.min_value    = val[15:0];
            REG_MAX_VALUE:    plot_cfg.max_value    = val[15:0];
            REG_COLOR_PAIR:   plot_cfg.color_pair   = val;
            default: ;
        endcase
    endtask

    // one sample transfer, sometimes with a random gap in front of it
    task send_sample(input logic [15:0] v, input int n_typed,
                     input draw_cmd_t r0, input draw_cmd_t r1);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        sample   <= v;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        plot_sample(v, n_typed == FROM_PLOTTER);
        if (n_typed > 0)
            cmd_q.push_back(r0);
        if (n_typed > 1)
            cmd_q.push_back(r1);
    endtask

    // hold the sender until every owed command is out, then let the block go quiet
    task settle_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (cmd_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task row_write(input logic [2:0] idx, input logic [31:0] val);
        stim_rows.push_back('{1'b1, idx, val, 0, '0, '0});
    endtask

    task row_sample(input logic [15:0] v);
        stim_rows.push_back('{1'b0, '0, {16'd0, v}, FROM_PLOTTER, '0, '0});
    endtask

    task row_typed(input logic [15:0] v, input int n, input draw_cmd_t r0, input draw_cmd_t r1);
        stim_rows.push_back('{1'b0, '0, {16'd0, v}, n, r0, r1});
    endtask

    // random register set: mostly narrow areas so the cursor wraps often
    task random_setup();
        int          mode;
        int          used_h;
        logic [15:0] fw;
        logic [15:0] fh;
        logic [7:0]  th;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] lo;
        logic [15:0] hi;
        mode = $urandom_range(0, 9);
        th   = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0)
            th = 8'd255;
        used_h = 2 + th;
        case (mode)
            0:       fw = 16'($urandom_range(0, 2));
            1:       fw = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(3, 65535));
            default: fw = 16'($urandom_range(3, 40));
        endcase
        case ($urandom_range(0, 11))
            0:       fh = 16'($urandom_range(0, used_h));
            1:       fh = 16'hFFFF;
            2:       fh = 16'(used_h + 1);
            3:       fh = 16'($urandom_range(used_h + 1, 65535));
            default: fh = 16'(used_h + $urandom_range(2, 200));
        endcase
        a = 16'($urandom_range(0, 65535));
        b = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 5))
            0:
            begin
                lo = 16'h0000;
                hi = 16'hFFFF;
            end
            1:
            begin
                // inverted range, everything lands on the bottom row
                lo = (a > b) ? a : b;
                hi = (a > b) ? b : a;
            end
            2:
            begin
                lo = a;
                hi = a;
            end
            default:
            begin
                lo = (a > b) ? b : a;
                hi = (a > b) ? a : b;
            end
        endcase
        cfg_write(REG_FRAME_X, $urandom());
        cfg_write(REG_FRAME_Y, $urandom());
        cfg_write(REG_FRAME_W, {16'd0, fw});
        cfg_write(REG_FRAME_H, {16'd0, fh});
        cfg_write(REG_TITLE_HEIGHT, {24'd0, th});
        cfg_write(REG_MIN_VALUE, {16'd0, lo});
        cfg_write(REG_MAX_VALUE, {16'd0, hi});
        cfg_write(REG_COLOR_PAIR, $urandom());
    endtask

    int          send_pcts[3] = '{15, 56, 0};
    int          recv_pcts[3] = '{56, 15, 0};
    int          n_items;
    int          pick;
    logic [15:0] smp_val;

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        sample   = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        // register reset values, state all zero
        plot_cfg.frame_x      = '0;
        plot_cfg.frame_y      = '0;
        plot_cfg.frame_w      = '0;
        plot_cfg.frame_h      = '0;
        plot_cfg.title_height = '0;
        plot_cfg.min_value    = 16'h0000;
        plot_cfg.max_value    = 16'hFFFF;
        plot_cfg.color_pair   = 32'hFFFF_0000;
        col_cursor      = '0;
        last_x          = '0;
        last_y          = '0;
        last_ok         = 1'b0;
        palette_swapped = 1'b0;

        // after reset the frame is zero size, so the sample is dropped
        row_typed(16'h1234, 0, '0, '0);
        // small frame at (10,20): data area 4 wide, 10 high, starting at (11,22)
        row_write(REG_FRAME_X, 32'd10);
        row_write(REG_FRAME_Y, 32'd20);
        row_write(REG_FRAME_W, 32'd6);
        row_write(REG_FRAME_H, 32'd13);
        row_write(REG_TITLE_HEIGHT, 32'd1);
        // min value on the bottom row, first point is a pixel
        row_typed(16'h0000, 2, mk_cmd(OP_FILL, 16'd11, 16'd22, 16'd1, 16'd10, 16'h0000, 1'b0),
                  mk_cmd(OP_PIXEL, 16'd11, 16'd31, 16'd11, 16'd31, 16'hFFFF, 1'b1));
        // max value on the top row, line from the previous point
        row_typed(16'hFFFF, 2, mk_cmd(OP_FILL, 16'd12, 16'd22, 16'd1, 16'd10, 16'h0000, 1'b0),
                  mk_cmd(OP_LINE, 16'd11, 16'd31, 16'd12, 16'd22, 16'hFFFF, 1'b1));
        row_sample(16'h8000);
        row_sample(16'h0001);
        // fifth column wraps to the left edge with swapped colors
        row_sample(16'hAAAA);
        // equal min and max
        row_write(REG_MIN_VALUE, 32'd1000);
        row_write(REG_MAX_VALUE, 32'd1000);
        row_sample(16'h5555);
        row_sample(16'h0005);
        // clamping below and above the range
        row_write(REG_MIN_VALUE, 32'd100);
        row_write(REG_MAX_VALUE, 32'd200);
        row_sample(16'd50);
        row_sample(16'd300);
        row_sample(16'd150);
        // max below min
        row_write(REG_MAX_VALUE, 32'd50);
        row_sample(16'hFFFF);
        // tallest title empties the small frame
        row_write(REG_TITLE_HEIGHT, 32'd255);
        row_typed(16'h0007, 0, '0, '0);
        row_write(REG_FRAME_H, 32'hFFFF);
        row_write(REG_MIN_VALUE, 32'd0);
        row_write(REG_MAX_VALUE, 32'hFFFF);
        row_sample(16'hC000);
        // one-row data area
        row_write(REG_TITLE_HEIGHT, 32'd0);
        row_write(REG_FRAME_H, 32'd3);
        row_sample(16'h00FF);
        // largest frame at the far corner, coordinates wrap
        row_write(REG_FRAME_X, 32'hFFFF);
        row_write(REG_FRAME_Y, 32'hFFFE);
        row_write(REG_FRAME_W, 32'hFFFF);
        row_write(REG_FRAME_H, 32'hFFFF);
        row_sample(16'h7FFF);
        row_sample(16'hFFFF);
        // area shrinks under the cursor
        row_write(REG_FRAME_W, 32'd3);
        row_sample(16'h0F0F);
        row_sample(16'hF0F0);
        row_write(REG_COLOR_PAIR, 32'h1234_ABCD);
        row_sample(16'h3C3C);
        // width of two leaves no data area
        row_write(REG_FRAME_W, 32'd2);
        row_typed(16'h9999, 0, '0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = send_pcts[0];
        recv_idle_pct = recv_pcts[0];
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].is_write)
            begin
                settle_block();
                cfg_write(stim_rows[i].idx, stim_rows[i].value);
            end
            else
                send_sample(stim_rows[i].value[15:0], stim_rows[i].n_typed,
                            stim_rows[i].r0, stim_rows[i].r1);
        end

        // random part: three idle phases, six register sets each
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = send_pcts[ph];
            recv_idle_pct = recv_pcts[ph];
            for (int ep = 0; ep < 6; ep++)
            begin
                settle_block();
                random_setup();
                n_items = $urandom_range(40, 66);
                for (int k = 0; k < n_items; k++)
                begin
                    // sender holds off until the block has emptied
                    if (ep == 2 && k == n_items / 2)
                        settle_block();
                    pick = $urandom_range(0, 9);
                    case (pick)
                        0:       smp_val = plot_cfg.min_value;
                        1:       smp_val = plot_cfg.max_value;
                        2:       smp_val = 16'h0000;
                        3:       smp_val = 16'hFFFF;
                        default: smp_val = 16'($urandom_range(0, 65535));
                    endcase
                    send_sample(smp_val, FROM_PLOTTER, '0, '0);
                end
            end
        end

        settle_block();
        if (mismatch_count == 0 && cmd_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
